### hw/rtl/rstp_pkg.sv
// ----------------------------------------------------------------------------
// rstp_pkg
// Shared types and constants of the rotary sector tracker positioner.
// ----------------------------------------------------------------------------
package rstp_pkg;

   localparam int SECTOR_COUNT = 12;
   localparam int QUEUE_LEN    = 12;

   localparam logic [3:0] SECTOR_TOP = 4'(SECTOR_COUNT);
   localparam logic [4:0] QUEUE_TOP  = 5'(QUEUE_LEN);
   localparam logic [4:0] GO_MAX     = 5'd16;
   localparam logic [4:0] DIAL_HOURS = 5'd12;

   localparam logic [15:0] DWELL_RESET  = 16'd10000;
   localparam logic [15:0] POLL_RESET   = 16'd2000;
   localparam logic [3:0]  WHITE_RESET  = 4'd0;
   localparam logic [4:0]  TARGET_RESET = 5'd1;

   localparam logic [1:0] REQ_NONE  = 2'd0;
   localparam logic [1:0] REQ_CLOCK = 2'd1;
   localparam logic [1:0] REQ_GO    = 2'd2;

   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] CSR_DWELL = 2'd0;
   localparam logic [1:0] CSR_POLL  = 2'd1;
   localparam logic [1:0] CSR_WHITE = 2'd2;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        reading_valid;
      logic [3:0]  color_class;
      logic        hour_valid;
      logic [4:0]  hour_of_day;
      logic [1:0]  req_type;
      logic [4:0]  go_target;
   } req_item_type;

   typedef struct packed {
      logic       motor_on;
      logic [3:0] sector_now;
      logic [4:0] target_now;
      logic       on_target;
      logic       sector_switched;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] dwell_ms;
      logic [15:0] clock_poll_ms;
      logic [3:0]  white_code;
   } cfg_type;

endpackage

### hw/rtl/rotary_sector_tracker_positioner.sv
// ----------------------------------------------------------------------------
// rotary_sector_tracker_positioner
// An accepted item is held in the input register, and its result is then
// captured in the result register. One item per cycle while the receiver
// does not stall; the control step is one pass of logic.
// Reset clears all tracker state and loads the configuration reset values.
// ----------------------------------------------------------------------------
module rotary_sector_tracker_positioner (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rstp_pkg::req_item_type           req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rstp_pkg::rsp_item_type           rsp_item,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rstp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import rstp_pkg::*;

   cfg_type      cfg;
   req_item_type in_item_ff;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type rsp_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type step_result;
   logic         advance;

   rstp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rstp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign in_valid_in  = req_stall ? 1'b1 : req_valid;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   stall_cause_a: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall) else $error("input stalled without cause");

   step_lands_a: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff) else $error("stepped item produced no result");

   held_result_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_item_ff))
      else $error("held result lost");

endmodule

### hw/rtl/rstp_csr.sv
// ----------------------------------------------------------------------------
// rstp_csr
// Configuration registers behind the bus port: dwell, poll interval, white code.
// ----------------------------------------------------------------------------
module rstp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rstp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output rstp_pkg::cfg_type                cfg
);
   import rstp_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            CSR_DWELL: cfg_in.dwell_ms      = csr_pwdata[15:0];
            CSR_POLL:  cfg_in.clock_poll_ms = csr_pwdata[15:0];
            CSR_WHITE: cfg_in.white_code    = csr_pwdata[3:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         CSR_DWELL: csr_prdata = {16'd0, cfg_ff.dwell_ms};
         CSR_POLL:  csr_prdata = {16'd0, cfg_ff.clock_poll_ms};
         CSR_WHITE: csr_prdata = {28'd0, cfg_ff.white_code};
         default:   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dwell_ms      <= DWELL_RESET;
         cfg_ff.clock_poll_ms <= POLL_RESET;
         cfg_ff.white_code    <= WHITE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/rstp_core.sv
// ----------------------------------------------------------------------------
// rstp_core
// Tracker state and the single-pass control step: command, color filter,
// clock poll, motor and target logic.
// ----------------------------------------------------------------------------
module rstp_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  rstp_pkg::req_item_type item,
   input  rstp_pkg::cfg_type      cfg,
   output rstp_pkg::rsp_item_type result
);
   import rstp_pkg::*;

   logic [3:0]  sector_ff, sector_in;
   logic [3:0]  stable_color_ff, stable_color_in;
   logic        stable_valid_ff, stable_valid_in;
   logic [1:0]  change_count_ff, change_count_in;
   logic [31:0] switch_time_ff, switch_time_in;
   logic [31:0] duration_ff, duration_in;
   logic [4:0]  target_ff, target_in;
   logic [4:0]  prev_target_ff, prev_target_in;
   logic [3:0]  queue_index_ff, queue_index_in;
   logic        found_ff, found_in;
   logic [31:0] entered_time_ff, entered_time_in;
   logic        move_ff, move_in;
   logic        clock_mode_ff, clock_mode_in;
   logic        queue_en_ff, queue_en_in;
   logic [31:0] last_poll_ff, last_poll_in;

   always_comb begin
      logic [4:0]  hour;
      logic [31:0] since_entry;
      logic [4:0]  qnext;
      logic        switched;
      logic        motor;

      sector_in       = sector_ff;
      stable_color_in = stable_color_ff;
      stable_valid_in = stable_valid_ff;
      change_count_in = change_count_ff;
      switch_time_in  = switch_time_ff;
      duration_in     = duration_ff;
      target_in       = target_ff;
      prev_target_in  = prev_target_ff;
      queue_index_in  = queue_index_ff;
      found_in        = found_ff;
      entered_time_in = entered_time_ff;
      move_in         = move_ff;
      clock_mode_in   = clock_mode_ff;
      queue_en_in     = queue_en_ff;
      last_poll_in    = last_poll_ff;
      switched        = 1'b0;
      hour            = item.hour_of_day;
      since_entry     = 32'd0;
      qnext           = 5'd0;

      case (item.req_type)
         REQ_CLOCK: begin
            clock_mode_in = 1'b1;
            queue_en_in   = 1'b0;
         end
         REQ_GO: begin
            clock_mode_in = 1'b0;
            queue_en_in   = 1'b1;
            if (item.go_target >= 5'd1 && item.go_target <= GO_MAX) begin
               target_in      = item.go_target;
               prev_target_in = 5'd0;
               found_in       = 1'b0;
            end
         end
         default: ;
      endcase

      if (item.reading_valid) begin
         if (!stable_valid_ff || item.color_class != stable_color_ff) begin
            change_count_in = change_count_ff + 2'd1;
         end
         if (change_count_in > 2'd1) begin
            switched        = 1'b1;
            duration_in     = item.now_ms - switch_time_ff;
            switch_time_in  = item.now_ms;
            change_count_in = 2'd0;
            stable_color_in = item.color_class;
            stable_valid_in = 1'b1;
            if (item.color_class == cfg.white_code) begin
               sector_in = SECTOR_TOP;
            end else if (sector_ff != 4'd0) begin
               sector_in = (sector_ff >= SECTOR_TOP) ? 4'd1 : sector_ff + 4'd1;
            end
         end
      end

      if (clock_mode_in && (item.now_ms - last_poll_ff) > {16'd0, cfg.clock_poll_ms}) begin
         last_poll_in = item.now_ms;
         if (item.hour_valid) begin
            if (hour > DIAL_HOURS) begin
               hour = hour - DIAL_HOURS;
            end
            target_in = hour;
         end
      end

      if (sector_in == 4'd0) begin
         motor = 1'b1;
      end else begin
         motor = move_ff;
         if ({1'b0, sector_in} == target_in) begin
            if (!found_in) begin
               entered_time_in = item.now_ms;
               found_in        = 1'b1;
            end
            since_entry = item.now_ms - entered_time_in;
            move_in     = (since_entry <= {1'b0, duration_in[31:1]});
            if (since_entry > {16'd0, cfg.dwell_ms} && prev_target_in != {1'b0, sector_in}
                && queue_en_in) begin
               qnext = {1'b0, queue_index_ff} + 5'd1;
               if (qnext >= QUEUE_TOP) begin
                  qnext = 5'd0;
               end
               queue_index_in = qnext[3:0];
               prev_target_in = target_in;
               target_in      = qnext + 5'd1;
               found_in       = 1'b0;
            end
         end else begin
            move_in = 1'b1;
         end
      end

      result.motor_on        = motor;
      result.sector_now      = sector_in;
      result.target_now      = target_in;
      result.on_target       = found_in;
      result.sector_switched = switched;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_ff       <= 4'd0;
         stable_color_ff <= 4'd0;
         stable_valid_ff <= 1'b0;
         change_count_ff <= 2'd0;
         switch_time_ff  <= 32'd0;
         duration_ff     <= 32'd0;
         target_ff       <= TARGET_RESET;
         prev_target_ff  <= 5'd0;
         queue_index_ff  <= 4'd0;
         found_ff        <= 1'b0;
         entered_time_ff <= 32'd0;
         move_ff         <= 1'b0;
         clock_mode_ff   <= 1'b1;
         queue_en_ff     <= 1'b0;
         last_poll_ff    <= 32'd0;
      end else if (step_en) begin
         sector_ff       <= sector_in;
         stable_color_ff <= stable_color_in;
         stable_valid_ff <= stable_valid_in;
         change_count_ff <= change_count_in;
         switch_time_ff  <= switch_time_in;
         duration_ff     <= duration_in;
         target_ff       <= target_in;
         prev_target_ff  <= prev_target_in;
         queue_index_ff  <= queue_index_in;
         found_ff        <= found_in;
         entered_time_ff <= entered_time_in;
         move_ff         <= move_in;
         clock_mode_ff   <= clock_mode_in;
         queue_en_ff     <= queue_en_in;
         last_poll_ff    <= last_poll_in;
      end
   end

   sector_range_a: assert property (@(posedge clock) disable iff (reset)
      sector_ff <= SECTOR_TOP) else $error("sector out of range");

   filter_count_a: assert property (@(posedge clock) disable iff (reset)
      change_count_ff <= 2'd1) else $error("color filter count left set");

   locate_needs_color_a: assert property (@(posedge clock) disable iff (reset)
      !stable_valid_ff |-> sector_ff == 4'd0)
      else $error("sector located without a stable color");

   queue_index_a: assert property (@(posedge clock) disable iff (reset)
      {1'b0, queue_index_ff} < QUEUE_TOP) else $error("queue index out of range");

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench for rotary_sector_tracker_positioner
// Drives control-loop passes through the item handshake and programs the
// dwell, poll and white-code registers between phases over the csr port.
// A scoreboard object tracks the positioner state itself (color filter,
// sector count, target, coasting, queue and clock polling) and checks every
// status item in order. Both sides idle in random bursts. The receiver also
// holds off for a long stretch once.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rstp_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;

   class positioner_scoreboard;
      rsp_item_type expected_status[$];
      int           mismatches;
      logic [15:0]  dwell_cfg;
      logic [15:0]  poll_cfg;
      logic [3:0]   white_cfg;
      logic [3:0]   sector;
      logic [3:0]   stable_color;
      bit           stable_ok;
      logic [1:0]   change_cnt;
      logic [31:0]  switch_ms;
      logic [31:0]  sector_ms;
      logic [31:0]  enter_ms;
      logic [31:0]  poll_ms;
      logic [4:0]   target;
      logic [4:0]   prev_target;
      logic [3:0]   queue_idx;
      bit           found;
      bit           moving;
      bit           clock_on;
      bit           queue_on;

      function new();
         mismatches   = 0;
         dwell_cfg    = DWELL_RESET;
         poll_cfg     = POLL_RESET;
         white_cfg    = WHITE_RESET;
         sector       = '0;
         stable_color = '0;
         stable_ok    = 1'b0;
         change_cnt   = '0;
         switch_ms    = '0;
         sector_ms    = '0;
         enter_ms     = '0;
         poll_ms      = '0;
         target       = TARGET_RESET;
         prev_target  = '0;
         queue_idx    = '0;
         found        = 1'b0;
         moving       = 1'b0;
         clock_on     = 1'b1;
         queue_on     = 1'b0;
      endfunction

      function void set_config(input logic [15:0] dwell, input logic [15:0] poll,
                               input logic [3:0] white);
         dwell_cfg = dwell;
         poll_cfg  = poll;
         white_cfg = white;
      endfunction

      function void note_item(input req_item_type it);
         rsp_item_type r;
         logic [31:0]  t;
         logic [4:0]   hr;
         bit           sw;
         bit           drive;
         t  = it.now_ms;
         sw = 1'b0;
         if (it.req_type == REQ_CLOCK) begin
            clock_on = 1'b1;
            queue_on = 1'b0;
         end else if (it.req_type == REQ_GO) begin
            clock_on = 1'b0;
            queue_on = 1'b1;
            if (it.go_target >= 5'd1 && it.go_target <= GO_MAX) begin
               target      = it.go_target;
               prev_target = '0;
               found       = 1'b0;
            end
         end
         if (it.reading_valid) begin
            if (!stable_ok || it.color_class != stable_color) change_cnt = change_cnt + 2'd1;
            if (change_cnt > 2'd1) begin
               sw           = 1'b1;
               sector_ms    = t - switch_ms;
               switch_ms    = t;
               change_cnt   = '0;
               stable_color = it.color_class;
               stable_ok    = 1'b1;
               if (it.color_class == white_cfg) begin
                  sector = SECTOR_TOP;
               end else if (sector != 4'd0) begin
                  sector = (sector >= SECTOR_TOP) ? 4'd1 : sector + 4'd1;
               end
            end
         end
         if (clock_on && (t - poll_ms) > {16'd0, poll_cfg}) begin
            poll_ms = t;
            if (it.hour_valid) begin
               hr = it.hour_of_day;
               if (hr > DIAL_HOURS) hr = hr - DIAL_HOURS;
               target = hr;
            end
         end
         if (sector == 4'd0) begin
            drive = 1'b1;
         end else begin
            drive = moving;
            if ({1'b0, sector} == target) begin
               if (!found) begin
                  enter_ms = t;
                  found    = 1'b1;
               end
               moving = ((t - enter_ms) <= (sector_ms >> 1));
               if ((t - enter_ms) > {16'd0, dwell_cfg} && prev_target != {1'b0, sector}
                   && queue_on) begin
                  queue_idx   = ({1'b0, queue_idx} + 5'd1 >= QUEUE_TOP) ? 4'd0
                                                                       : queue_idx + 4'd1;
                  prev_target = target;
                  target      = {1'b0, queue_idx} + 5'd1;
                  found       = 1'b0;
               end
            end else begin
               moving = 1'b1;
            end
         end
         r.motor_on        = drive;
         r.sector_now      = sector;
         r.target_now      = target;
         r.on_target       = found;
         r.sector_switched = sw;
         expected_status.push_back(r);
      endfunction

      function void check_result(input rsp_item_type got);
         rsp_item_type exp;
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected status item: motor=%0d sector=%0d target=%0d found=%0d sw=%0d",
                        got.motor_on, got.sector_now, got.target_now, got.on_target,
                        got.sector_switched);
            return;
         end
         exp = expected_status.pop_front();
         if (got.motor_on !== exp.motor_on || got.sector_now !== exp.sector_now ||
             got.target_now !== exp.target_now || got.on_target !== exp.on_target ||
             got.sector_switched !== exp.sector_switched) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("status mismatch: expected motor=%0d sector=%0d target=%0d found=%0d sw=%0d",
                        exp.motor_on, exp.sector_now, exp.target_now, exp.on_target,
                        exp.sector_switched);
               $display("                 got motor=%0d sector=%0d target=%0d found=%0d sw=%0d",
                        got.motor_on, got.sector_now, got.target_now, got.on_target,
                        got.sector_switched);
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_item_type          req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_item_type          rsp_item;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   positioner_scoreboard sb = new();
   logic [31:0] clock_ms = '0;
   logic [3:0]  pend_color = '0;
   logic [3:0]  disc_color = '0;
   bit          pend_left = 1'b0;
   bit          quiet = 1'b0;
   bit          long_hold_req = 1'b0;
   int          stall_left = 0;
   int          cycle_count = 0;

   rotary_sector_tracker_positioner DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL rotary_sector_tracker_positioner");
         $finish;
      end
   end

   // status receiver with random and long hold-offs
   always begin
      @(posedge clock);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_item);
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         stall_left    = 300;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 6) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(input req_item_type it);
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      sb.note_item(it);
   endtask

   task automatic send_fields(input logic [31:0] t, input bit rv, input logic [3:0] c,
                              input bit hv, input logic [4:0] h, input logic [1:0] rq,
                              input logic [4:0] g);
      req_item_type it;
      it.now_ms        = t;
      it.reading_valid = rv;
      it.color_class   = c;
      it.hour_valid    = hv;
      it.hour_of_day   = h;
      it.req_type      = rq;
      it.go_target     = g;
      clock_ms         = t;
      send_item(it);
   endtask

   function automatic req_item_type random_item();
      req_item_type it;
      int           roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) clock_ms = $urandom();
      else if (roll < 8) clock_ms += $urandom_range(0, 30000);
      else clock_ms += $urandom_range(0, 500);
      it.now_ms        = clock_ms;
      it.color_class   = 4'($urandom_range(0, 15));
      it.reading_valid = 1'b0;
      roll = $urandom_range(0, 99);
      if (pend_left) begin
         it.reading_valid = 1'b1;
         it.color_class   = pend_color;
         pend_left        = 1'b0;
      end else if (roll < 35) begin
         if ($urandom_range(0, 5) == 0) begin
            pend_color = sb.white_cfg;
         end else begin
            do pend_color = 4'($urandom_range(0, 15)); while (pend_color == disc_color);
         end
         disc_color       = pend_color;
         it.reading_valid = 1'b1;
         it.color_class   = pend_color;
         pend_left        = 1'b1;
      end else if (roll < 45) begin
         it.reading_valid = 1'b1;
      end
      it.hour_valid  = ($urandom_range(0, 99) < 85);
      it.hour_of_day = ($urandom_range(0, 99) < 90) ? 5'($urandom_range(0, 23))
                                                    : 5'($urandom_range(24, 31));
      roll = $urandom_range(0, 99);
      if (roll < 90) it.req_type = REQ_NONE;
      else if (roll < 94) it.req_type = REQ_CLOCK;
      else if (roll < 99) it.req_type = REQ_GO;
      else it.req_type = REQ_UNUSED;
      it.go_target = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(1, 12))
                                                  : 5'($urandom_range(0, 31));
      return it;
   endfunction

   task automatic run_items(input int count);
      repeat (count) begin
         send_item(random_item());
         if (!quiet && $urandom_range(0, 99) < 8) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (sb.expected_status.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic reconfigure(input logic [15:0] dwell, input logic [15:0] poll,
                              input logic [3:0] white);
      drain();
      repeat (4) @(posedge clock);
      csr_write(CSR_DWELL, 32'(dwell));
      csr_write(CSR_POLL, 32'(poll));
      csr_write(CSR_WHITE, 32'(white));
      sb.set_config(dwell, poll, white);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      reconfigure(DWELL_RESET, POLL_RESET, WHITE_RESET);

      // directed passes, white code 0
      send_fields(32'd0, 1'b0, 4'd0, 1'b0, 5'd0, REQ_NONE, 5'd0);
      send_fields(32'd100, 1'b1, 4'd5, 1'b1, 5'd3, REQ_NONE, 5'd0);
      // color accepted while the sector is still unknown
      send_fields(32'd200, 1'b1, 4'd5, 1'b1, 5'd3, REQ_NONE, 5'd0);
      send_fields(32'd300, 1'b1, 4'd0, 1'b1, 5'd3, REQ_NONE, 5'd0);
      send_fields(32'd400, 1'b1, 4'd0, 1'b1, 5'd3, REQ_NONE, 5'd0);
      send_fields(32'd2500, 1'b0, 4'd0, 1'b1, 5'd23, REQ_NONE, 5'd0);
      // hour zero gives an unreachable target
      send_fields(32'd5000, 1'b0, 4'd0, 1'b1, 5'd0, REQ_NONE, 5'd0);
      send_fields(32'd7100, 1'b0, 4'd15, 1'b1, 5'd31, REQ_NONE, 5'd0);
      send_fields(32'd9200, 1'b0, 4'd0, 1'b0, 5'd5, REQ_NONE, 5'd0);
      send_fields(32'd9300, 1'b0, 4'd0, 1'b1, 5'd12, REQ_UNUSED, 5'd0);
      send_fields(32'd9400, 1'b0, 4'd0, 1'b1, 5'd12, REQ_GO, 5'd0);
      send_fields(32'd9500, 1'b0, 4'd0, 1'b1, 5'd12, REQ_GO, 5'd31);
      send_fields(32'd9600, 1'b0, 4'd0, 1'b1, 5'd12, REQ_GO, 5'd16);
      send_fields(32'd9700, 1'b0, 4'd0, 1'b1, 5'd12, REQ_GO, 5'd12);
      send_fields(32'd9800, 1'b0, 4'd0, 1'b1, 5'd12, REQ_NONE, 5'd0);
      send_fields(32'd9900, 1'b0, 4'd0, 1'b1, 5'd12, REQ_NONE, 5'd0);
      send_fields(32'd20000, 1'b0, 4'd0, 1'b1, 5'd12, REQ_NONE, 5'd0);
      // wrap from the top sector, then reach the queued target
      send_fields(32'd20100, 1'b1, 4'd7, 1'b0, 5'd0, REQ_NONE, 5'd0);
      send_fields(32'd20200, 1'b1, 4'd7, 1'b0, 5'd0, REQ_NONE, 5'd0);
      send_fields(32'd20300, 1'b1, 4'd9, 1'b0, 5'd0, REQ_NONE, 5'd0);
      send_fields(32'd20400, 1'b1, 4'd9, 1'b0, 5'd0, REQ_NONE, 5'd0);
      send_fields(32'hFFFF_FF00, 1'b0, 4'd9, 1'b0, 5'd0, REQ_NONE, 5'd0);
      send_fields(32'hFFFF_FFFF, 1'b0, 4'd9, 1'b1, 5'd24, REQ_CLOCK, 5'd0);
      send_fields(32'h0000_0010, 1'b1, 4'd15, 1'b1, 5'd24, REQ_NONE, 5'd0);
      disc_color = 4'd9;

      run_items(280);
      reconfigure(16'd0, 16'd0, 4'd15);
      run_items(300);
      reconfigure(16'hFFFF, 16'hFFFF, 4'd9);
      run_items(300);
      reconfigure(16'($urandom_range(0, 20000)), 16'($urandom_range(0, 5000)),
                  4'($urandom_range(0, 15)));
      run_items(150);
      drain();
      run_items(150);
      reconfigure(16'd500, 16'd100, 4'd3);
      long_hold_req = 1'b1;
      run_items(300);
      reconfigure(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 3000)),
                  4'($urandom_range(0, 15)));
      quiet = 1'b1;
      run_items(300);

      drain();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_status.size() == 0)
         $display("PASS rotary_sector_tracker_positioner");
      else
         $display("FAIL rotary_sector_tracker_positioner");
      $finish;
   end
endmodule
